@@ rtl/core/dtq_pkg.sv @@
package dtq_pkg;

	localparam int DEPTH      = 16;
	localparam int TIME_BITS  = 32;
	localparam int TAG_W      = 16;
	localparam int DELAY_W    = 31;
	localparam int OTIME_W    = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 56;
	localparam int USER_W     = 2;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [TAG_W-1:0]     tag_t;
	typedef logic [IDX_W-1:0]     idx_t;

	typedef enum logic [1:0] {
		CMD_SCHED = 2'd0,
		CMD_TICK  = 2'd1,
		CMD_STOP  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_DUE    = 2'd2,
		KIND_STOP   = 2'd3
	} kind_t;

	// contents of one queue slot, handed down the row on a removal
	typedef struct packed {
		logic  valid;
		time_t dl;
		tag_t  tag;
	} slot_t;

	// search token walking the row, one cell per cycle
	typedef struct packed {
		logic  go;
		logic  found;
		time_t dl;
		tag_t  tag;
		idx_t  idx;
	} cand_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic  ins;
		logic  shift;
		idx_t  rm_idx;
		time_t now;
		time_t new_dl;
		tag_t  new_tag;
	} cell_ctrl_t;

endpackage

@@ rtl/core/dtq_cell.sv @@
module dtq_cell
	import dtq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  idx_t       idx,
	input  cell_ctrl_t ctrl,
	input  logic       prev_valid,
	input  slot_t      next_slot,
	input  cand_t      cand_in,
	output slot_t      slot,
	output logic       due,
	output cand_t      cand_out
);

	logic  valid_q;
	time_t dl_q;
	tag_t  tag_q;
	logic  go_q;
	logic  found_q;
	time_t cdl_q;
	tag_t  ctag_q;
	idx_t  cidx_q;

	time_t age;
	time_t gap;
	logic  take_own;
	logic  shift_in;
	logic  load_new;

	// due once now - deadline is not negative
	assign age = ctrl.now - dl_q;
	assign due = valid_q && !age[TIME_BITS-1];

	// strictly earlier only, so the lowest slot wins a tie
	assign gap      = dl_q - cand_in.dl;
	assign take_own = cand_in.go && due && (!cand_in.found || gap[TIME_BITS-1]);

	assign shift_in = ctrl.shift && (idx >= ctrl.rm_idx);
	assign load_new = ctrl.ins && !valid_q && prev_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			go_q    <= 1'b0;
			found_q <= 1'b0;
		end else begin
			go_q    <= cand_in.go;
			found_q <= take_own ? 1'b1 : cand_in.found;
			if (shift_in) begin
				valid_q <= next_slot.valid;
			end else if (load_new) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (shift_in) begin
			dl_q  <= next_slot.dl;
			tag_q <= next_slot.tag;
		end else if (load_new) begin
			dl_q  <= ctrl.new_dl;
			tag_q <= ctrl.new_tag;
		end
		if (take_own) begin
			cdl_q  <= dl_q;
			ctag_q <= tag_q;
			cidx_q <= idx;
		end else begin
			cdl_q  <= cand_in.dl;
			ctag_q <= cand_in.tag;
			cidx_q <= cand_in.idx;
		end
	end

	assign slot     = '{valid: valid_q, dl: dl_q, tag: tag_q};
	assign cand_out = '{go: go_q, found: found_q, dl: cdl_q, tag: ctag_q, idx: cidx_q};

endmodule

@@ rtl/core/deadline_timer_queue_top.sv @@
// Deadline timer queue: a tick counter plus a row of DEPTH slot cells kept in insertion
// order. Schedule and stop items give one result each. A tick item advances time, then
// for each due job a search token walks the row one cell per cycle, the winner is sent
// out and removed by shifting the later cells down; a tick with nothing due gives no
// result. One item is in work at a time; input is taken again once the block is idle
// and the output register is free.
module deadline_timer_queue_top
	import dtq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // job_tag[15:0], delay_ticks[46:16], zero[47]
	input  logic [USER_W-1:0]     s_tuser,  // command[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // due_tag[15:0], due_time[47:16], finished[48]
	output logic [USER_W-1:0]     m_tuser,  // kind[1:0]
	output logic                  m_tlast
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_PICK = 3'b100
	} state_t;

	state_t state_q;
	logic   start_q;
	logic   stop_q;
	time_t  time_q;
	cand_t  pick_q;
	logic   pick_found_q;

	logic   m_tvalid_q;
	kind_t  kind_q;
	tag_t   otag_q;
	time_t  otime_q;
	logic   fin_q;
	logic   last_q;

	cmd_t       cmd;
	tag_t       in_tag;
	time_t      new_dl;
	logic       out_free;
	logic       acc;
	logic       full;
	logic       all_due;
	logic       rest_due;
	logic       emit;
	logic       load_out;
	cell_ctrl_t ctrl;

	slot_t              slot_chain [DEPTH+1];
	cand_t              cand_chain [DEPTH+1];
	logic [DEPTH-1:0]   valid_vec;
	logic [DEPTH-1:0]   due_vec;
	logic [DEPTH-1:0]   go_vec;
	logic [DEPTH-1:0]   valid_inc;

	assign cmd      = cmd_t'(s_tuser[1:0]);
	assign in_tag   = s_tdata[TAG_W-1:0];
	assign new_dl   = time_q + TIME_BITS'(s_tdata[TAG_W +: DELAY_W]);
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign acc      = s_tvalid && s_tready;
	assign full     = valid_vec[DEPTH-1];
	assign all_due  = &(due_vec | ~valid_vec);
	// due mask holds still from the scan to the pick, so the rest tells whether this is the last one
	assign rest_due = |(due_vec & ~(DEPTH'(1) << pick_q.idx));
	assign emit     = (state_q == ST_PICK) && pick_found_q && out_free;
	assign load_out = (acc && (cmd == CMD_SCHED || cmd == CMD_STOP)) || emit;

	assign ctrl = '{
		ins:     acc && (cmd == CMD_SCHED) && !full,
		shift:   emit,
		rm_idx:  pick_q.idx,
		now:     time_q,
		new_dl:  new_dl,
		new_tag: in_tag
	};

	assign slot_chain[DEPTH] = '0;
	assign cand_chain[0]     = '{go: start_q, found: 1'b0, dl: '0, tag: '0, idx: '0};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic pv;
		if (i == 0) begin : g_head
			assign pv = 1'b1;
		end else begin : g_body
			assign pv = slot_chain[i-1].valid;
		end

		dtq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (IDX_W'(i)),
			.ctrl       (ctrl),
			.prev_valid (pv),
			.next_slot  (slot_chain[i+1]),
			.cand_in    (cand_chain[i]),
			.slot       (slot_chain[i]),
			.due        (due_vec[i]),
			.cand_out   (cand_chain[i+1])
		);

		assign valid_vec[i] = slot_chain[i].valid;
		assign go_vec[i]    = cand_chain[i+1].go;
	end

	assign valid_inc = valid_vec + DEPTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			start_q      <= 1'b0;
			stop_q       <= 1'b0;
			time_q       <= '0;
			pick_found_q <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (cmd)
							CMD_TICK: begin
								time_q  <= time_q + TIME_BITS'(1);
								start_q <= 1'b1;
								state_q <= ST_SCAN;
							end
							CMD_STOP: stop_q <= 1'b1;
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (cand_chain[DEPTH].go) begin
						pick_found_q <= cand_chain[DEPTH].found;
						state_q      <= ST_PICK;
					end
				end
				ST_PICK: begin
					if (!pick_found_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						if (rest_due) begin
							start_q <= 1'b1;
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && cand_chain[DEPTH].go) begin
			pick_q <= cand_chain[DEPTH];
		end
		if (emit) begin
			kind_q  <= KIND_DUE;
			otag_q  <= pick_q.tag;
			otime_q <= pick_q.dl;
			fin_q   <= stop_q && all_due;
			last_q  <= !rest_due;
		end else if (acc && cmd == CMD_SCHED) begin
			kind_q  <= full ? KIND_REJECT : KIND_ACCEPT;
			otag_q  <= in_tag;
			otime_q <= new_dl;
			fin_q   <= 1'b0;
			last_q  <= 1'b1;
		end else if (acc && cmd == CMD_STOP) begin
			kind_q  <= KIND_STOP;
			otag_q  <= '0;
			otime_q <= time_q;
			fin_q   <= !valid_vec[0];
			last_q  <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_DATA_W - OTIME_W - TAG_W - 1){1'b0}}, fin_q,
		OTIME_W'(otime_q), otag_q};

`ifndef SYNTH
	// occupied slots always form a prefix of the row
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & valid_inc) == '0)
		else $error("slot occupancy is not a prefix");

	// at most one search token in flight
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(go_vec))
		else $error("more than one search token in the row");

	// the job picked for removal is really due
	a_pick_due: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK && pick_found_q) |-> due_vec[pick_q.idx])
		else $error("picked slot is not due");

	// no insert into a full row
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |-> !full)
		else $error("insert while queue is full");

	// a removal is only in idle-free picking, never while a token walks
	a_shift_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.shift |-> (go_vec == '0 && !start_q))
		else $error("removal while search is running");
`endif

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
	import dtq_pkg::*;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam int MAX_DUE_PER_TICK = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 64;

	typedef struct {
		kind_t               kind;
		tag_t                tag;
		logic [OTIME_W-1:0]  due_time;
		logic                finished;
		logic                last;
	} timer_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // job_tag[15:0], delay_ticks[46:16], zero[47]
	logic [USER_W-1:0]     s_tuser;   // command[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // due_tag[15:0], due_time[47:16], finished[48]
	logic [USER_W-1:0]     m_tuser;   // kind[1:0]
	logic                  m_tlast;

	deadline_timer_queue_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// shadow of the queue: insertion-ordered slots
	time_t clock_now;
	time_t slot_dl [DEPTH];
	tag_t  slot_tg [DEPTH];
	int    slot_count;
	logic  stop_seen;

	timer_reply_t queue_replies[$];
	int mismatch_count;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_cycles;

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// true when a - b is negative in TIME_BITS signed arithmetic
	function automatic logic earlier(input time_t a, input time_t b);
		time_t diff;
		diff = a - b;
		return diff[TIME_BITS-1];
	endfunction

	function automatic void add_reply(input kind_t kind, input tag_t tag, input time_t t,
			input logic fin, input logic last);
		timer_reply_t r;
		r.kind = kind;
		r.tag = tag;
		r.due_time = t[OTIME_W-1:0];
		r.finished = fin;
		r.last = last;
		queue_replies.push_back(r);
	endfunction

	function automatic void apply_command(input logic [1:0] cmd, input tag_t tag,
			input logic [DELAY_W-1:0] delay);
		time_t dl;
		time_t due_dl [MAX_DUE_PER_TICK];
		tag_t  due_tg [MAX_DUE_PER_TICK];
		int    count;
		int    best;
		int    i;
		int    k;
		if (cmd == CMD_SCHED) begin
			dl = clock_now + time_t'(delay);
			if (slot_count >= DEPTH) begin
				add_reply(KIND_REJECT, tag, dl, 1'b0, 1'b1);
			end else begin
				slot_dl[slot_count] = dl;
				slot_tg[slot_count] = tag;
				slot_count++;
				add_reply(KIND_ACCEPT, tag, dl, 1'b0, 1'b1);
			end
		end else if (cmd == CMD_TICK) begin
			clock_now = clock_now + 1;
			count = 0;
			while (count < MAX_DUE_PER_TICK) begin
				best = -1;
				for (i = 0; i < slot_count; i++) begin
					if (earlier(clock_now, slot_dl[i]))
						continue;
					if (best < 0 || earlier(slot_dl[i], slot_dl[best]))
						best = i;
				end
				if (best < 0)
					break;
				due_dl[count] = slot_dl[best];
				due_tg[count] = slot_tg[best];
				count++;
				for (i = best; i + 1 < slot_count; i++) begin
					slot_dl[i] = slot_dl[i+1];
					slot_tg[i] = slot_tg[i+1];
				end
				slot_count--;
			end
			for (k = 0; k < count; k++)
				add_reply(KIND_DUE, due_tg[k], due_dl[k], stop_seen && slot_count == 0,
					k == count - 1);
		end else if (cmd == CMD_STOP) begin
			stop_seen = 1'b1;
			add_reply(KIND_STOP, '0, clock_now, slot_count == 0, 1'b1);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		timer_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (queue_replies.size() == 0) begin
				report_mismatch("unexpected item, kind", 32'(m_tuser), 32'hffffffff);
			end else begin
				want = queue_replies.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
				if (m_tdata[15:0] !== want.tag)
					report_mismatch("due_tag", 32'(m_tdata[15:0]), 32'(want.tag));
				if (m_tdata[47:16] !== want.due_time)
					report_mismatch("due_time", m_tdata[47:16], want.due_time);
				if (m_tdata[48] !== want.finished)
					report_mismatch("finished", 32'(m_tdata[48]), 32'(want.finished));
				if (m_tdata[OUT_DATA_W-1:49] !== '0)
					report_mismatch("tdata padding", 32'(m_tdata[OUT_DATA_W-1:49]), 0);
				if (m_tlast !== want.last)
					report_mismatch("last", 32'(m_tlast), 32'(want.last));
			end
		end
	end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// entered and left at a falling edge; valid stays up so back-to-back items flow
	task automatic send_item(input logic [1:0] cmd, input tag_t tag,
			input logic [DELAY_W-1:0] delay);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, delay, tag};
		s_tuser <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		apply_command(cmd, tag, delay);
		@(negedge clk);
	endtask

	function automatic logic [DELAY_W-1:0] random_delay();
		if ($urandom_range(0, 9) == 0)
			return DELAY_W'($urandom_range(0, 150));
		return DELAY_W'($urandom_range(0, 24));
	endfunction

	// fill to the brim with deadlines now and now+1, one reject, then one tick drains all
	task automatic test_full_queue();
		tag_t tag;
		int i;
		for (i = 0; i < DEPTH; i++) begin
			tag = (i == 0) ? 16'h0000 : (i == DEPTH - 1) ? 16'hffff : tag_t'($urandom);
			send_item(CMD_SCHED, tag, (i % 2 == 0) ? 31'd1 : 31'd0);
		end
		send_item(CMD_SCHED, tag_t'($urandom), {DELAY_W{1'b1}});
		send_item(CMD_TICK, tag_t'($urandom), 31'(random_delay()));
	endtask

	task automatic test_stop_and_idle();
		send_item(CMD_SCHED, 16'h5a5a, 31'd2);
		send_item(CMD_STOP, tag_t'($urandom), 31'($urandom));
		send_item(CMD_TICK, tag_t'($urandom), 31'($urandom));   // nothing due yet
		send_item(CMD_TICK, tag_t'($urandom), 31'($urandom));   // drains, queue empty
		send_item(CMD_UNKNOWN, tag_t'($urandom), 31'($urandom));
		send_item(CMD_SCHED, 16'ha5a5, 31'd0);                  // accepted after stop
		send_item(CMD_TICK, tag_t'($urandom), 31'($urandom));
	endtask

	task automatic test_random_traffic(input int n_items, input int spct, input int rpct);
		int sent;
		int pick;
		int burst;
		sent = 0;
		send_idle_pct = spct;
		recv_idle_pct = rpct;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// bursts push the queue toward full
				burst = $urandom_range(3, 10);
				repeat (burst)
					send_item(CMD_SCHED, tag_t'($urandom), random_delay());
				sent += burst;
			end else if (pick < 52) begin
				send_item(CMD_SCHED, tag_t'($urandom), random_delay());
				sent++;
			end else if (pick < 92) begin
				send_item(CMD_TICK, tag_t'($urandom), 31'($urandom));
				sent++;
			end else if (pick < 96) begin
				send_item(CMD_STOP, tag_t'($urandom), 31'($urandom));
				sent++;
			end else begin
				send_item(CMD_UNKNOWN, tag_t'($urandom), 31'($urandom));
			end
		end
	endtask

	task automatic test_long_delay();
		send_item(CMD_SCHED, 16'hffff, {DELAY_W{1'b1}});
		send_item(CMD_TICK, tag_t'($urandom), 31'($urandom));
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (queue_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		mismatch_count = 0;
		stall_cycles = 0;
		clock_now = '0;
		slot_count = 0;
		stop_seen = 1'b0;
		repeat (2)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_full_queue();
		test_stop_and_idle();
		test_random_traffic(100, 25, 73);
		test_random_traffic(100, 73, 25);
		test_random_traffic(100, 0, 0);
		test_long_delay();
		drain_and_settle();

		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/dtq_pkg.sv
rtl/core/dtq_cell.sv
rtl/core/deadline_timer_queue_top.sv
tb/sv/testbench.sv
